@@ src/imu_fd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame deframer package
// Shared constants and types of the IMU frame deframer and its float scaler.
// ----------------------------------------------------------------------------
package imu_fd_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 59;
    localparam logic [7:0]  HDR_BYTE        = 8'h5A;
    localparam int unsigned FLOAT_START     = 2;
    localparam int unsigned FLOAT_END       = 26;
    localparam int unsigned NUM_WORDS       = 6;
    localparam int unsigned NUM_RATE_WORDS  = 3;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned WIDX_W          = 3;

    localparam logic [31:0] GYRO_SCALE_RST  = 32'd292818;
    localparam logic [31:0] ACCEL_SCALE_RST = 32'd164574822;

    localparam logic REG_GYRO_SCALE  = 1'b0;
    localparam logic REG_ACCEL_SCALE = 1'b1;

    typedef enum logic [1:0] {
        SYNC_HUNT  = 2'd0,
        SYNC_HDR1  = 2'd1,
        SYNC_FRAME = 2'd2
    } t_sync;

    typedef struct packed {
        logic              vld;
        logic [WIDX_W-1:0] idx;
        logic [WORD_W-1:0] value;
    } t_conv_res;

endpackage

@@ src/imu_fd_conv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU float scaler
// Converts the six collected IEEE single words, one per cycle, into scaled
// and saturated signed Q16.16 values through one shared multiplier.
// ----------------------------------------------------------------------------
module imu_fd_conv (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  logic [imu_fd_pkg::NUM_WORDS-1:0][imu_fd_pkg::WORD_W-1:0] i_words,
    input  logic [31:0]                                           i_gyro_scale,
    input  logic [31:0]                                           i_accel_scale,
    output logic                                                  o_busy,
    output imu_fd_pkg::t_conv_res                                 o_res
);
    import imu_fd_pkg::*;

    localparam logic [7:0] EXP_BIAS_Q = 8'd158;
    localparam logic [7:0] EXP_SPEC   = 8'hFF;

    logic              r_iss_act, n_iss_act;
    logic [WIDX_W-1:0] r_iss_idx, n_iss_idx;

    logic              r_s1_vld;
    logic [WIDX_W-1:0] r_s1_idx;
    logic [55:0]       r_s1_prod;
    logic [7:0]        r_s1_ex;
    logic              r_s1_neg;
    logic              r_s1_spec;

    logic              r_s2_vld;
    logic [WIDX_W-1:0] r_s2_idx;
    logic [31:0]       r_s2_mag;
    logic              r_s2_neg;

    t_conv_res         r_res;

    logic [31:0] sel_word;
    logic [31:0] sel_scale;
    logic [7:0]  raw_ex;
    logic [23:0] mant;
    logic [7:0]  eff_ex;
    logic [55:0] prod;

    logic [31:0] limit;
    logic [7:0]  sh_l;
    logic [7:0]  sh_r;
    logic [87:0] wide;
    logic        sat;
    logic [31:0] mag;

    always_comb begin
        n_iss_act = r_iss_act;
        n_iss_idx = r_iss_idx;
        if (i_start) begin
            n_iss_act = 1'b1;
            n_iss_idx = '0;
        end else if (r_iss_act) begin
            n_iss_idx = r_iss_idx + WIDX_W'(1);
            if (r_iss_idx == WIDX_W'(NUM_WORDS - 1)) begin
                n_iss_act = 1'b0;
            end
        end
    end

    always_comb begin
        sel_word  = (r_iss_idx < WIDX_W'(NUM_WORDS)) ? i_words[r_iss_idx] : '0;
        sel_scale = (r_iss_idx < WIDX_W'(NUM_RATE_WORDS)) ? i_gyro_scale : i_accel_scale;
        raw_ex    = sel_word[30:23];
        if (raw_ex == 8'd0) begin
            mant   = {1'b0, sel_word[22:0]};
            eff_ex = 8'd1;
        end else begin
            mant   = {1'b1, sel_word[22:0]};
            eff_ex = raw_ex;
        end
        prod = 56'(mant) * 56'(sel_scale);
    end

    always_comb begin
        limit = r_s1_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sh_l  = r_s1_ex - EXP_BIAS_Q;
        sh_r  = EXP_BIAS_Q - r_s1_ex;
        sat   = r_s1_spec;
        if (r_s1_ex >= EXP_BIAS_Q) begin
            wide = {32'd0, r_s1_prod} << sh_l[4:0];
            if ((sh_l >= 8'd32) && (r_s1_prod != '0)) begin
                sat = 1'b1;
            end
        end else if (sh_r >= 8'd56) begin
            wide = '0;
        end else begin
            wide = {32'd0, r_s1_prod >> sh_r[5:0]};
        end
        if (wide > {56'd0, limit}) begin
            sat = 1'b1;
        end
        mag = sat ? limit : wide[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_act <= 1'b0;
            r_iss_idx <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_res.vld <= 1'b0;
        end else begin
            r_iss_act <= n_iss_act;
            r_iss_idx <= n_iss_idx;
            r_s1_vld  <= r_iss_act;
            r_s2_vld  <= r_s1_vld;
            r_res.vld <= r_s2_vld;
        end
        r_s1_idx    <= r_iss_idx;
        r_s1_prod   <= prod;
        r_s1_ex     <= eff_ex;
        r_s1_neg    <= sel_word[31];
        r_s1_spec   <= (raw_ex == EXP_SPEC);
        r_s2_idx    <= r_s1_idx;
        r_s2_mag    <= mag;
        r_s2_neg    <= r_s1_neg;
        r_res.idx   <= r_s2_idx;
        r_res.value <= r_s2_neg ? (32'd0 - r_s2_mag) : r_s2_mag;
    end

    assign o_busy = r_iss_act | r_s1_vld | r_s2_vld | r_res.vld;
    assign o_res  = r_res;

endmodule

@@ src/imu_frame_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame deframer core
// Finds header-synchronised IMU frames in a byte stream, checks their 8-bit
// sum and emits six scaled Q16.16 sensor values for every good frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle. When the last byte of a frame
// lands with a good checksum, the six collected floats pass through a shared
// multiplier, one per cycle, and the result transfer is offered once all six
// scaled values are stored. Bytes of the next frame are taken meanwhile; the
// input holds off only on the last byte of a frame while the previous result
// is still being converted or waits to be taken. Configuration is read and
// written through the APB port without wait states.
module imu_frame_deframer_core #(
    parameter int unsigned FRAME_BYTES = imu_fd_pkg::FRAME_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import imu_fd_pkg::*;

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);

    t_sync              r_sync, n_sync;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_sum, n_sum;
    logic [NUM_WORDS-1:0][WORD_W-1:0] r_words;
    logic [NUM_WORDS-1:0][WORD_W-1:0] r_res;
    logic               r_out_vld, n_out_vld;
    logic [31:0]        r_gyro_scale;
    logic [31:0]        r_accel_scale;

    logic               s_acc;
    logic               last_pos;
    logic               is_hdr;
    logic               hdr_done;
    logic               frame_byte;
    logic               frame_end;
    logic               hunt_byte;
    logic               conv_start;
    logic               conv_busy;
    t_conv_res          conv_res;
    logic               cfg_wr;
    logic [4:0]         float_off;

    assign s_acc    = s_axis_tvalid & s_axis_tready;
    assign last_pos = (r_pos == POS_W'(FRAME_BYTES - 1));
    assign is_hdr   = (s_axis_tdata == HDR_BYTE);

    assign s_axis_tready = !((r_sync == SYNC_FRAME) && last_pos &&
                             (conv_busy || (r_out_vld && !m_axis_tready)));

    always_comb begin
        n_sync = r_sync;
        if (s_acc) begin
            case (r_sync)
                SYNC_HUNT:  n_sync = is_hdr ? SYNC_HDR1 : SYNC_HUNT;
                SYNC_HDR1:  n_sync = is_hdr ? SYNC_FRAME : SYNC_HUNT;
                SYNC_FRAME: n_sync = last_pos ? SYNC_HUNT : SYNC_FRAME;
                default:    n_sync = is_hdr ? SYNC_HDR1 : SYNC_HUNT;
            endcase
        end
    end

    always_comb begin
        hdr_done   = 1'b0;
        frame_byte = 1'b0;
        frame_end  = 1'b0;
        hunt_byte  = 1'b0;
        case (r_sync)
            SYNC_HDR1:  hdr_done   = s_acc && is_hdr;
            SYNC_FRAME: begin
                frame_byte = s_acc && !last_pos;
                frame_end  = s_acc && last_pos;
            end
            default:    hunt_byte  = s_acc;
        endcase
    end

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (hdr_done) begin
            n_pos = POS_W'(FLOAT_START);
            n_sum = '0;
        end else if (frame_byte) begin
            n_pos = r_pos + POS_W'(1);
            n_sum = r_sum + s_axis_tdata;
        end else if (hunt_byte || frame_end) begin
            n_pos = '0;
        end
    end

    assign conv_start = frame_end && (s_axis_tdata == r_sum);

    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (conv_res.vld && (conv_res.idx == WIDX_W'(NUM_WORDS - 1))) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= SYNC_HUNT;
            r_pos     <= '0;
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_sync    <= n_sync;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_out_vld <= n_out_vld;
        end
    end

    assign float_off = 5'(r_pos - POS_W'(FLOAT_START));

    always_ff @(posedge i_clk) begin
        if (frame_byte && (r_pos >= POS_W'(FLOAT_START)) && (r_pos < POS_W'(FLOAT_END))) begin
            r_words[float_off[4:2]][float_off[1:0]*8 +: 8] <= s_axis_tdata;
        end
        if (conv_res.vld) begin
            r_res[conv_res.idx] <= conv_res.value;
        end
    end

    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_scale  <= GYRO_SCALE_RST;
            r_accel_scale <= ACCEL_SCALE_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GYRO_SCALE) begin
                r_gyro_scale <= pwdata;
            end else begin
                r_accel_scale <= pwdata;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GYRO_SCALE) ? r_gyro_scale : r_accel_scale;

    imu_fd_conv u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (conv_start),
        .i_words       (r_words),
        .i_gyro_scale  (r_gyro_scale),
        .i_accel_scale (r_accel_scale),
        .o_busy        (conv_busy),
        .o_res         (conv_res)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_res;

    // A conversion is only started when the scaler is free.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_start |-> !conv_busy)
        else $error("conversion started while scaler busy");

    // Results are never written over a result that still waits to be taken.
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_res.vld |-> !r_out_vld)
        else $error("scaler result overwrote pending output");

    // Inside a frame the position never falls below the first float byte.
    a_pos_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sync == SYNC_FRAME) |-> (r_pos >= POS_W'(FLOAT_START)))
        else $error("frame position below first payload byte");

    // The input only holds off on the last byte of a frame.
    a_stall_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> ((r_sync == SYNC_FRAME) && last_pos))
        else $error("input stalled outside the last frame byte");

endmodule
